@@ design/oled_pixel_shadow_writer_top_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the pixel shadow writer
// Clocked property checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef OLED_PIXEL_SHADOW_WRITER_TOP_ASSERT_SVH
`define OLED_PIXEL_SHADOW_WRITER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// check prop on every rising clock edge, idle while reset is asserted
`define OPSW_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check prop on every rising clock edge, including during reset
`define OPSW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OPSW_ASSERT(lbl, clk, rst_n, prop, msg)
`define OPSW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ design/opsw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Pixel shadow writer package
// Geometry, bus codes and panel codes shared by the design files.
// ---------------------------------------------------------------------------
package opsw_pkg;

	// shadow geometry
	localparam int PAGE_WIDTH   = 128;
	localparam int PAGE_COUNT   = 8;
	localparam int SHADOW_DEPTH = PAGE_WIDTH * PAGE_COUNT;
	localparam int ADDR_W       = $clog2(SHADOW_DEPTH);

	// input field widths
	localparam int X_W    = 8;
	localparam int Y_W    = 7;
	localparam int BIT_W  = 3;
	localparam int PAGE_W = Y_W - BIT_W;

	// widest index that a pixel write can form
	localparam int IDX_W = $clog2(((2 ** PAGE_W) - 1) * PAGE_WIDTH + (2 ** X_W));

	// adjusted column and page widths
	localparam int COL_W     = X_W + 1;
	localparam int PAGE_ADJ_W = PAGE_W + 1;

	// stream payload widths
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 8;
	localparam int OUT_USER_W = 3;

	// bus codes
	localparam logic [7:0] CTRL_CMD    = 8'h00;
	localparam logic [7:0] CTRL_DATA   = 8'h40;
	localparam logic [7:0] CMD_PAGE    = 8'hB0;
	localparam logic [7:0] CMD_COL_HI  = 8'h10;

	// panel offsets
	localparam int COL_OFS_CENTRED  = 32;
	localparam int COL_OFS_WIDE     = 2;
	localparam int PAGE_OFS_CENTRED = 4;

	// panel types
	localparam logic [1:0] PANEL_128X64   = 2'd0;
	localparam logic [1:0] PANEL_128X32   = 2'd1;
	localparam logic [1:0] PANEL_CENTRED  = 2'd2;
	localparam logic [1:0] PANEL_WIDE     = 2'd3;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PANEL_TYPE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_MODE  = 1'b1;

endpackage
`default_nettype wire

@@ design/opsw_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module opsw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ design/oled_pixel_shadow_writer_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// OLED pixel shadow writer
// Flow: accepted pixel -> LOOKUP (shadow read) -> EMIT, which registers its
//   results one per cycle while the output is free: eight bus bytes if the
//   pixel changed, else one result. The single shadow read/modify/write
//   sets the per-item cost; no pixel is taken before the last result is out.
// Reset: asynchronous; afterwards a clearing pass zeroes the shadow RAM,
//   during which no pixel is accepted (config writes still are).
// ---------------------------------------------------------------------------
module oled_pixel_shadow_writer_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// pixel input
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// [7:0] pixel_x, [14:8] pixel_y, [15] colour
	input  wire logic [opsw_pkg::IN_DATA_W-1:0]    s_tdata,
	// bus byte output
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// [7:0] bus_byte
	output logic      [opsw_pkg::OUT_DATA_W-1:0]   m_tdata,
	// [0] byte_valid, [1] end_of_transfer, [2] status
	output logic      [opsw_pkg::OUT_USER_W-1:0]   m_tuser,
	// last result of one pixel write
	output logic                                   m_tlast,
	// configuration write port
	input  wire logic                              cfg_we,
	input  wire logic [opsw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [opsw_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import opsw_pkg::*;

`include "oled_pixel_shadow_writer_top_assert.svh"

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_EMIT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [1:0] panel_type_q;
	logic       flip_mode_q;

	// clearing pass address
	logic [ADDR_W-1:0] clr_addr_q;

	// per-item datapath, captured at the input transaction
	logic [ADDR_W-1:0] addr_q;
	logic [BIT_W-1:0]  bit_q;
	logic              colour_q;
	logic              off_q;
	logic [7:0]        page_cmd_q;
	logic [COL_W-1:0]  col_q;

	// captured after the shadow read
	logic [7:0]        byte_q;
	logic              single_q;
	logic [2:0]        cnt_q;

	// input field unpacking
	logic [X_W-1:0]    in_x;
	logic [Y_W-1:0]    in_y;
	logic              in_colour;
	logic [PAGE_W-1:0] in_page;
	logic [IDX_W-1:0]  in_idx;
	logic              in_off;
	logic              in_accept;

	// bus position math
	logic [PAGE_ADJ_W-1:0] page_adj;
	logic [COL_W-1:0]      col_adj;

	// read-modify-write
	logic [7:0]        ram_rdata;
	logic [7:0]        bit_mask;
	logic [7:0]        new_byte;
	logic              changed;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;

	// next result item
	logic [7:0]        seq_byte;
	logic              out_free;

	assign in_x      = s_tdata[X_W-1:0];
	assign in_y      = s_tdata[X_W+Y_W-1:X_W];
	assign in_colour = s_tdata[X_W+Y_W];
	assign in_page   = in_y[Y_W-1:BIT_W];

	// index = page * PAGE_WIDTH + x; x past the page width spills into the next page
	assign in_idx = IDX_W'(in_page) * IDX_W'(PAGE_WIDTH) + IDX_W'(in_x);
	assign in_off = in_idx > IDX_W'(SHADOW_DEPTH - 1);

	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;

	// panel offsets: centred panel shifts columns and, unless flipped, pages; wide panel shifts columns
	always_comb begin
		page_adj = PAGE_ADJ_W'(in_page);
		col_adj  = COL_W'(in_x);
		case (panel_type_q)
			PANEL_CENTRED: begin
				col_adj = COL_W'(in_x) + COL_W'(COL_OFS_CENTRED);
				if (!flip_mode_q) begin
					page_adj = PAGE_ADJ_W'(in_page) + PAGE_ADJ_W'(PAGE_OFS_CENTRED);
				end
			end
			PANEL_WIDE: begin
				col_adj = COL_W'(in_x) + COL_W'(COL_OFS_WIDE);
			end
			PANEL_128X64, PANEL_128X32: begin
				col_adj = COL_W'(in_x);
			end
			default: begin
				col_adj = COL_W'(in_x);
			end
		endcase
	end

	// shadow RAM: the read is issued with the input transaction and returns
	// during LOOKUP, where the modified byte is written back. The next read
	// cannot start before that write, so no forwarding is needed.
	opsw_ram #(
		.WIDTH(8),
		.DEPTH(SHADOW_DEPTH)
	) u_shadow (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (in_idx[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	assign bit_mask = 8'(1) << bit_q;
	assign new_byte = colour_q ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
	assign changed  = (new_byte != ram_rdata);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = new_byte;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = 8'h00;
		end else if (state_q == ST_LOOKUP) begin
			ram_we = !off_q && changed;
		end
	end

	// eight-byte bus sequence: three command transfers, then one data transfer
	always_comb begin
		case (cnt_q)
			3'd1:    seq_byte = page_cmd_q;
			3'd3:    seq_byte = {4'h0, col_q[3:0]};
			3'd5:    seq_byte = CMD_COL_HI | {4'h0, col_q[7:4]};
			3'd6:    seq_byte = CTRL_DATA;
			3'd7:    seq_byte = byte_q;
			default: seq_byte = CTRL_CMD;
		endcase
	end

	assign out_free = !m_tvalid || m_tready;

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			addr_q     <= in_idx[ADDR_W-1:0];
			bit_q      <= in_y[BIT_W-1:0];
			colour_q   <= in_colour;
			off_q      <= in_off;
			page_cmd_q <= CMD_PAGE | 8'(page_adj);
			col_q      <= col_adj;
		end
		if (state_q == ST_LOOKUP) begin
			byte_q <= new_byte;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_type_q <= PANEL_128X64;
			flip_mode_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PANEL_TYPE: panel_type_q <= cfg_data[1:0];
				REG_FLIP_MODE:  flip_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			single_q   <= 1'b0;
			cnt_q      <= '0;
			m_tvalid   <= 1'b0;
			m_tdata    <= '0;
			m_tuser    <= '0;
			m_tlast    <= 1'b0;
		end else begin
			// drop the output once taken; a load below overrides
			if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == ADDR_W'(SHADOW_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					// off-screen or unchanged: one lone result, status set only if off-screen, nothing sent
					single_q <= off_q || !changed;
					cnt_q    <= '0;
					state_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					// advance one result per cycle while the output is free
					if (out_free) begin
						m_tvalid <= 1'b1;
						if (single_q) begin
							m_tdata <= '0;
							m_tuser <= {off_q, 1'b0, 1'b0};
							m_tlast <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							m_tdata <= seq_byte;
							m_tuser <= {1'b0, cnt_q[0], 1'b1};
							m_tlast <= (cnt_q == 3'd7);
							cnt_q   <= cnt_q + 3'd1;
							if (cnt_q == 3'd7) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// an accepted pixel always goes straight to the shadow lookup
	`OPSW_ASSERT(a_accept_lookup, clk, arst_n, in_accept |=> (state_q == ST_LOOKUP), "accepted pixel did not go to lookup")
	// an off-screen pixel never touches the shadow
	`OPSW_ASSERT(a_no_offscreen_write, clk, arst_n, (ram_we && (state_q == ST_LOOKUP)) |-> !off_q, "off-screen pixel wrote the shadow")
	// end of transfer only marks bytes that are sent
	`OPSW_ASSERT(a_eot_valid, clk, arst_n, (m_tvalid && m_tuser[1]) |-> m_tuser[0], "end of transfer without a bus byte")
	// an off-screen status result is a lone, final result with no byte
	`OPSW_ASSERT(a_status_single, clk, arst_n, (m_tvalid && m_tuser[2]) |-> (m_tlast && !m_tuser[0]), "status result is not a lone result")
	// no pixel is taken while the clearing pass runs
	`OPSW_ASSERT_ALWAYS(a_clear_blocks, clk, (state_q == ST_CLEAR) |-> !s_tready, "pixel accepted during clearing pass")

endmodule
`default_nettype wire

@@ tb/oled_pixel_shadow_writer_top_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pixel shadow writer regression bench
// Drives pixel writes into the stream input, predicts the bus bytes from a
// local copy of the shadow memory and panel settings, and checks every output
// transaction in order. A directed table runs first, then random phases under
// different panel settings with random idling on both sides.
// ---------------------------------------------------------------------------
module oled_pixel_shadow_writer_top_tb;
	import opsw_pkg::*;

	localparam int CYCLE_LIMIT    = 200000;
	localparam int HOLDOFF_CYCLES = 120;
	localparam int DRAIN_CYCLES   = 12;
	localparam int RANDOM_PHASES  = 5;
	localparam int PHASE_ITEMS    = 22;
	localparam int REPORT_LIMIT   = 10;

	// one output transaction as the bench sees it
	typedef struct packed {
		logic [7:0] bus_byte;
		logic       byte_valid;
		logic       eot;
		logic       status;
		logic       last;
	} bus_result_t;

	// how a stimulus row gets its expected results
	typedef enum logic [1:0] {
		EXP_MODEL,       // from the predictor
		EXP_OFF_SCREEN,  // single result, status set
		EXP_UNCHANGED,   // single result, nothing sent
		EXP_BUS_SEQ      // eight bytes typed in the row, first byte in the top bits
	} exp_kind_t;

	typedef struct {
		bit                     is_reg_write;
		logic [CFG_IDX_W-1:0]   reg_idx;
		logic [CFG_DATA_W-1:0]  reg_val;
		logic [7:0]             px;
		logic [6:0]             py;
		logic                   pc;
		exp_kind_t              kind;
		logic [63:0]            seq;
	} stim_row_t;

	// DUT signals, all known from time zero
	logic                    clk      = 1'b0;
	logic                    arst_n   = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [IN_DATA_W-1:0]    s_tdata  = '0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]   m_tdata;
	logic [OUT_USER_W-1:0]   m_tuser;
	logic                    m_tlast;
	logic                    cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data  = '0;

	// predictor state: shadow memory and panel settings
	logic [7:0]  shadow_mem [SHADOW_DEPTH];
	logic [1:0]  panel_sel;
	logic        flip_sel;
	bus_result_t pred_out [8];
	int          pred_count;

	// expected bus bytes, oldest first
	bus_result_t bus_expect_q [$];
	stim_row_t   stim_rows [$];

	// idling controls for the sender and the receiver
	int tx_idle_pct = 13;
	int rx_idle_pct = 13;
	int holdoff_req = 0;
	int holdoff_ack = 0;
	int holdoff_left = 0;

	// bookkeeping
	int cycle_count    = 0;
	int mismatch_count = 0;
	int bytes_checked  = 0;
	int writes_changed = 0;
	int writes_same    = 0;
	int writes_off     = 0;
	int reg_writes     = 0;

	oled_pixel_shadow_writer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// -----------------------------------------------------------------------
	// Predictor: apply one pixel write to the shadow copy and fill pred_out
	// -----------------------------------------------------------------------
	function automatic void predict_pixel_write(input logic [7:0] px, input logic [6:0] py,
			input logic pc);
		logic [3:0] page;
		logic [2:0] bitpos;
		int         idx;
		logic [7:0] old_b;
		logic [7:0] new_b;
		logic [8:0] col;
		logic [4:0] bus_page;
		logic [7:0] seq [8];

		page   = py[6:3];
		bitpos = py[2:0];
		idx    = int'(page) * PAGE_WIDTH + int'(px);
		pred_count = 1;
		// a column past the page width is legal; only the whole index is bounded
		if (idx > SHADOW_DEPTH - 1) begin
			pred_out[0] = '{bus_byte: 8'h00, byte_valid: 1'b0, eot: 1'b0, status: 1'b1,
				last: 1'b1};
			return;
		end
		old_b = shadow_mem[idx];
		new_b = old_b;
		new_b[bitpos] = pc;
		if (new_b == old_b) begin
			pred_out[0] = '{bus_byte: 8'h00, byte_valid: 1'b0, eot: 1'b0, status: 1'b0,
				last: 1'b1};
			return;
		end
		shadow_mem[idx] = new_b;
		// panel offsets apply to the bus address only, never to the shadow index
		col      = {1'b0, px};
		bus_page = {1'b0, page};
		if (panel_sel == PANEL_CENTRED) begin
			col = col + 9'(COL_OFS_CENTRED);
			if (!flip_sel)
				bus_page = bus_page + 5'(PAGE_OFS_CENTRED);
		end else if (panel_sel == PANEL_WIDE) begin
			col = col + 9'(COL_OFS_WIDE);
		end
		seq[0] = CTRL_CMD;
		seq[1] = CMD_PAGE | {3'b000, bus_page};
		seq[2] = CTRL_CMD;
		seq[3] = {4'h0, col[3:0]};
		seq[4] = CTRL_CMD;
		seq[5] = CMD_COL_HI | {4'h0, col[7:4]};
		seq[6] = CTRL_DATA;
		seq[7] = new_b;
		pred_count = 8;
		for (int k = 0; k < 8; k++)
			pred_out[k] = '{bus_byte: seq[k], byte_valid: 1'b1, eot: k[0], status: 1'b0,
				last: (k == 7)};
	endfunction

	// queue the expectations for one accepted pixel write
	function automatic void record_accepted_write(input stim_row_t row);
		predict_pixel_write(row.px, row.py, row.pc);
		if (pred_count == 8)
			writes_changed++;
		else if (pred_out[0].status)
			writes_off++;
		else
			writes_same++;
		case (row.kind)
			EXP_OFF_SCREEN: begin
				bus_expect_q.push_back('{bus_byte: 8'h00, byte_valid: 1'b0, eot: 1'b0,
					status: 1'b1, last: 1'b1});
			end
			EXP_UNCHANGED: begin
				bus_expect_q.push_back('{bus_byte: 8'h00, byte_valid: 1'b0, eot: 1'b0,
					status: 1'b0, last: 1'b1});
			end
			EXP_BUS_SEQ: begin
				for (int k = 0; k < 8; k++)
					bus_expect_q.push_back('{bus_byte: row.seq[63 - 8 * k -: 8],
						byte_valid: 1'b1, eot: k[0], status: 1'b0, last: (k == 7)});
			end
			default: begin
				for (int k = 0; k < pred_count; k++)
					bus_expect_q.push_back(pred_out[k]);
			end
		endcase
	endfunction

	function automatic void add_pixel_row(input logic [7:0] px, input logic [6:0] py,
			input logic pc, input exp_kind_t kind, input logic [63:0] seq);
		stim_row_t row;

		row = '{is_reg_write: 1'b0, reg_idx: '0, reg_val: '0, px: px, py: py, pc: pc,
			kind: kind, seq: seq};
		stim_rows.push_back(row);
	endfunction

	function automatic void add_reg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		stim_row_t row;

		row = '{is_reg_write: 1'b1, reg_idx: idx, reg_val: val, px: '0, py: '0, pc: 1'b0,
			kind: EXP_MODEL, seq: '0};
		stim_rows.push_back(row);
	endfunction

	// -----------------------------------------------------------------------
	// Sender: random gap, offer the item, hold until the transaction, predict
	// -----------------------------------------------------------------------
	task automatic offer_pixel(input stim_row_t row);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {row.pc, row.py, row.px};
		do
			@(posedge clk);
		while (!s_tready);
		record_accepted_write(row);
	endtask

	// drop valid and wait until every expected bus byte has come out
	task automatic settle_bus;
		s_tvalid <= 1'b0;
		while (bus_expect_q.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// register write; only called while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_PANEL_TYPE)
			panel_sel = val;
		else if (idx == REG_FLIP_MODE)
			flip_sel = val[0];
		reg_writes++;
	endtask

	// random pixel write, biased toward on-screen addresses that get revisited
	function automatic stim_row_t random_pixel_row;
		stim_row_t row;
		int        pick;

		pick = $urandom_range(99);
		row = '{is_reg_write: 1'b0, reg_idx: '0, reg_val: '0, px: '0, py: '0,
			pc: 1'($urandom_range(1)), kind: EXP_MODEL, seq: '0};
		if (pick < 20) begin
			// anything the fields allow, off screen included
			row.px = 8'($urandom_range(255));
			row.py = 7'($urandom_range(127));
		end else if (pick < 35) begin
			// column past the page width, wrapping into the next page
			row.px = 8'($urandom_range(255, 128));
			row.py = 7'($urandom_range(55));
		end else begin
			// small hot region at both page edges so pixels get set and cleared again
			row.px = 8'($urandom_range(7) + ($urandom_range(1) ? 120 : 0));
			row.py = 7'($urandom_range(63));
		end
		return row;
	endfunction

	// -----------------------------------------------------------------------
	// Receiver: random stalls, plus a long hold-off when one is requested
	// -----------------------------------------------------------------------
	always @(posedge clk) begin
		if (holdoff_left > 0) begin
			m_tready <= 1'b0;
			holdoff_left = holdoff_left - 1;
		end else if (holdoff_req != holdoff_ack) begin
			holdoff_ack  = holdoff_req;
			holdoff_left = HOLDOFF_CYCLES - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// -----------------------------------------------------------------------
	// Checker: compare each output transaction with the oldest expectation
	// -----------------------------------------------------------------------
	task automatic flag_mismatch(input string what, input bus_result_t want,
			input bus_result_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("[%0t] %s: expected byte %02h valid %b eot %b status %b last %b, got byte %02h valid %b eot %b status %b last %b",
				$time, what, want.bus_byte, want.byte_valid, want.eot, want.status, want.last,
				got.bus_byte, got.byte_valid, got.eot, got.status, got.last);
	endtask

	always @(posedge clk) begin
		bus_result_t got;
		bus_result_t want;

		if (arst_n && m_tvalid && m_tready) begin
			got = '{bus_byte: m_tdata, byte_valid: m_tuser[0], eot: m_tuser[1],
				status: m_tuser[2], last: m_tlast};
			if (bus_expect_q.size() == 0) begin
				flag_mismatch("output with nothing expected", '0, got);
			end else begin
				want = bus_expect_q.pop_front();
				bytes_checked++;
				if (got.bus_byte !== want.bus_byte || got.byte_valid !== want.byte_valid ||
						got.eot !== want.eot || got.status !== want.status ||
						got.last !== want.last)
					flag_mismatch("bus byte mismatch", want, got);
			end
		end
	end

	// hard stop if the run hangs
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bus bytes still expected", cycle_count,
				bus_expect_q.size());
			$display("oled_pixel_shadow_writer_top regression: fail");
			$finish;
		end
	end

	// -----------------------------------------------------------------------
	// Main sequence
	// -----------------------------------------------------------------------
	initial begin
		stim_row_t row;

		for (int i = 0; i < SHADOW_DEPTH; i++)
			shadow_mem[i] = 8'h00;
		panel_sel = PANEL_128X64;
		flip_sel  = 1'b0;

		// directed table: shadow starts cleared, default panel
		add_pixel_row(8'd0,   7'd0,   1'b0, EXP_UNCHANGED,  '0);
		add_pixel_row(8'd0,   7'd0,   1'b1, EXP_BUS_SEQ,    64'h00B0_0000_0010_4001);
		add_pixel_row(8'd0,   7'd0,   1'b1, EXP_UNCHANGED,  '0);
		// last byte of the shadow, bottom pixel
		add_pixel_row(8'd127, 7'd63,  1'b1, EXP_BUS_SEQ,    64'h00B7_000F_0017_4080);
		// one past the end, and the far corner of the field ranges
		add_pixel_row(8'd128, 7'd63,  1'b1, EXP_OFF_SCREEN, '0);
		add_pixel_row(8'd255, 7'd127, 1'b1, EXP_OFF_SCREEN, '0);
		add_pixel_row(8'd0,   7'd64,  1'b0, EXP_OFF_SCREEN, '0);
		// wide column runs into the next page of the shadow, bus keeps the raw column
		add_pixel_row(8'd200, 7'd8,   1'b1, EXP_BUS_SEQ,    64'h00B1_0008_001C_4001);
		add_pixel_row(8'd72,  7'd23,  1'b1, EXP_MODEL,      '0);
		add_pixel_row(8'd0,   7'd0,   1'b0, EXP_BUS_SEQ,    64'h00B0_0000_0010_4000);
		add_reg_row(REG_PANEL_TYPE, PANEL_128X32);
		add_pixel_row(8'd5,   7'd10,  1'b1, EXP_MODEL,      '0);
		add_pixel_row(8'd5,   7'd10,  1'b0, EXP_MODEL,      '0);
		// centred panel: column +32, page +4 while not flipped
		add_reg_row(REG_PANEL_TYPE, PANEL_CENTRED);
		add_pixel_row(8'd0,   7'd8,   1'b1, EXP_BUS_SEQ,    64'h00B5_0000_0012_4001);
		add_pixel_row(8'd10,  7'd63,  1'b1, EXP_MODEL,      '0);
		add_reg_row(REG_FLIP_MODE, 2'd1);
		add_pixel_row(8'd1,   7'd8,   1'b1, EXP_BUS_SEQ,    64'h00B1_0001_0012_4001);
		add_pixel_row(8'd255, 7'd0,   1'b1, EXP_MODEL,      '0);
		// wide panel: column +2, column carry past eight bits
		add_reg_row(REG_PANEL_TYPE, PANEL_WIDE);
		add_pixel_row(8'd254, 7'd48,  1'b1, EXP_MODEL,      '0);
		add_pixel_row(8'd3,   7'd56,  1'b1, EXP_MODEL,      '0);
		add_reg_row(REG_FLIP_MODE, 2'd0);
		add_pixel_row(8'd127, 7'd0,   1'b1, EXP_MODEL,      '0);

		// hold reset, then release it; the clearing pass after it holds off the input
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (stim_rows[i]) begin
			if (stim_rows[i].is_reg_write) begin
				settle_bus();
				write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
			end else begin
				offer_pixel(stim_rows[i]);
			end
		end
		settle_bus();

		// random phases, each under its own panel setting
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin write_reg(REG_PANEL_TYPE, PANEL_WIDE);    write_reg(REG_FLIP_MODE, 2'd1); end
				1: begin write_reg(REG_PANEL_TYPE, PANEL_CENTRED); write_reg(REG_FLIP_MODE, 2'd0); end
				2: begin write_reg(REG_PANEL_TYPE, PANEL_128X32);  write_reg(REG_FLIP_MODE, 2'd0); end
				3: begin write_reg(REG_PANEL_TYPE, PANEL_128X64);  write_reg(REG_FLIP_MODE, 2'd1); end
				default: begin
					write_reg(REG_PANEL_TYPE, PANEL_CENTRED);
					write_reg(REG_FLIP_MODE, 2'd1);
				end
			endcase
			// phase 1 runs with no idling at all; phase 2 starts with a long hold-off
			tx_idle_pct = (ph == 1) ? 0 : 13;
			rx_idle_pct = (ph == 1) ? 0 : 13;
			if (ph == 2)
				holdoff_req = holdoff_req + 1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				row = random_pixel_row();
				offer_pixel(row);
			end
			settle_bus();
		end

		// let any stray output show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d pixel writes: %0d changed, %0d unchanged, %0d off screen",
			writes_changed + writes_same + writes_off, writes_changed, writes_same, writes_off);
		$display("checked %0d bus bytes across %0d register writes, all panel types, both flips",
			bytes_checked, reg_writes);
		if (mismatch_count == 0 && bus_expect_q.size() == 0) begin
			$display("oled_pixel_shadow_writer_top regression: pass");
		end else begin
			$display("%0d mismatches, %0d bus bytes never seen", mismatch_count,
				bus_expect_q.size());
			$display("oled_pixel_shadow_writer_top regression: fail");
		end
		$finish;
	end

endmodule
